/* design/flvsa_pkg.sv */
// shared types and constants for the load vector scatter-add block
`timescale 1ns / 1ps
`default_nettype none

package flvsa_pkg;

    localparam int IDX_W         = 12;
    localparam int NUM_LANES     = 4;
    localparam int MAX_DIMENSION = 3;
    localparam int ACC_W         = 48;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 2;

    // command codes
    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ       = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_USE_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_GRAD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_DIM = 2'd2;

    typedef logic signed [31:0] q16_t;
    typedef q16_t [NUM_LANES-1:0] q16_lanes_t;

    typedef struct packed {
        logic                   command;
        logic [IDX_W-1:0]       dof_index;
        logic signed [31:0]     weight;
        logic signed [31:0]     shape_value;
        logic signed [31:0]     value_coef;
        logic signed [31:0]     shape_grad_x;
        logic signed [31:0]     shape_grad_y;
        logic signed [31:0]     shape_grad_z;
        logic signed [31:0]     coef_grad_x;
        logic signed [31:0]     coef_grad_y;
        logic signed [31:0]     coef_grad_z;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]       read_index;
        logic signed [ACC_W-1:0] total;
        logic                   saturated;
    } out_item_t;

    typedef struct packed {
        logic       use_value_term;
        logic       use_gradient_term;
        logic [1:0] space_dimension;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_ACC,
        JOB_READ,
        JOB_READ_NULL
    } job_kind_t;

    typedef struct packed {
        job_kind_t              kind;
        logic [IDX_W-1:0]       dof_index;
        logic [NUM_LANES-1:0]   lane_en;
        q16_t                   weight;
        q16_lanes_t             lhs;
        q16_lanes_t             rhs;
    } job_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_WMUL,
        ST_ACC,
        ST_RDATA,
        ST_OUT
    } back_state_t;

endpackage

`default_nettype wire

/* design/flvsa_front.sv */
// front end: takes requests, classifies them and queues jobs for the back end
`timescale 1ns / 1ps
`default_nettype none

module flvsa_front #(
    parameter int NUM_DOFS = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire flvsa_pkg::in_item_t s_data,
    input  wire flvsa_pkg::cfg_t   cfg,
    input  wire logic              clear_busy,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output flvsa_pkg::job_t        job
);
    import flvsa_pkg::*;

    localparam int QDEPTH = 2;

    job_t       q_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    job_t       job_new;
    logic       in_range;
    logic       push;
    logic       pop;
    logic [1:0] dim;

    always_comb begin
        in_range = 32'(s_data.dof_index) < 32'(NUM_DOFS);
        dim = (32'(cfg.space_dimension) > 32'(MAX_DIMENSION)) ?
              2'(MAX_DIMENSION) : cfg.space_dimension;

        job_new.dof_index = s_data.dof_index;
        job_new.weight    = s_data.weight;
        if (s_data.command == CMD_READ) begin
            job_new.kind = in_range ? JOB_READ : JOB_READ_NULL;
        end else begin
            job_new.kind = JOB_ACC;
        end
        // lane 0 is the value term, lanes 1..3 the gradient components
        job_new.lane_en[0] = cfg.use_value_term;
        for (int d = 1; d < NUM_LANES; d++) begin
            job_new.lane_en[d] = cfg.use_gradient_term && (d <= int'(dim));
        end
        job_new.lhs[0] = s_data.shape_value;
        job_new.rhs[0] = s_data.value_coef;
        job_new.lhs[1] = s_data.shape_grad_x;
        job_new.rhs[1] = s_data.coef_grad_x;
        job_new.lhs[2] = s_data.shape_grad_y;
        job_new.rhs[2] = s_data.coef_grad_y;
        job_new.lhs[3] = s_data.shape_grad_z;
        job_new.rhs[3] = s_data.coef_grad_z;
    end

    assign s_ready   = !clear_busy && (cnt_reg != 2'(QDEPTH));
    // out-of-range accumulates are taken and dropped here
    assign push      = s_valid && s_ready && ((s_data.command == CMD_READ) || in_range);
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= job_new;
        end
    end

endmodule

`default_nettype wire

/* design/flvsa_back.sv */
// back end: product datapath, accumulator memory and result register
`timescale 1ns / 1ps
`default_nettype none

module flvsa_back #(
    parameter int NUM_DOFS = 4096
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               job_valid,
    output logic                    job_ready,
    input  wire flvsa_pkg::job_t    job,
    output logic                    clear_busy,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output flvsa_pkg::out_item_t    m_data
);
    import flvsa_pkg::*;

    localparam int AW    = (NUM_DOFS > 1) ? $clog2(NUM_DOFS) : 1;
    localparam int ENT_W = ACC_W + 1;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    back_state_t state_reg, state_next;

    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    job_t                   job_reg;
    logic signed [63:0]     prod_reg [NUM_LANES];
    logic signed [31:0]     c_reg;
    logic                   csat_reg;
    logic signed [63:0]     wprod_reg;
    logic signed [ACC_W-1:0] res_total_reg;
    logic                   res_sat_reg;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg;

    // accumulator store: {sticky flag, sum}
    logic [ENT_W-1:0]       mem [NUM_DOFS];
    logic [ENT_W-1:0]       rd_data_reg;
    logic                   mem_rd;
    logic                   mem_we;
    logic [AW-1:0]          mem_addr;
    logic [ENT_W-1:0]       mem_wdata;

    // control strobes
    logic take_job;
    logic load_prod;
    logic load_c;
    logic load_wprod;
    logic load_res;
    logic load_res_null;
    logic load_out;
    logic out_free;

    // datapath
    logic signed [65:0]     sum66;
    logic signed [49:0]     c_wide;
    logic                   c_ovf;
    logic signed [31:0]     c_sat;
    logic signed [63:0]     wround;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_old;
    logic signed [ACC_W:0]  acc_sum;
    logic                   acc_ovf;
    logic signed [ACC_W-1:0] acc_new;
    logic                   flag_new;

    assign out_free   = !m_valid_reg || m_ready;
    assign clear_busy = (state_reg == ST_CLEAR);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        job_ready     = 1'b0;
        take_job      = 1'b0;
        load_prod     = 1'b0;
        load_c        = 1'b0;
        load_wprod    = 1'b0;
        load_res      = 1'b0;
        load_res_null = 1'b0;
        load_out      = 1'b0;
        mem_rd        = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = AW'(job_reg.dof_index);
        mem_wdata     = '0;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (32'(clr_cnt_reg) == NUM_DOFS - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    take_job = 1'b1;
                    case (job.kind)
                        JOB_ACC: begin
                            state_next = ST_MUL;
                        end
                        JOB_READ: begin
                            mem_rd     = 1'b1;
                            mem_addr   = AW'(job.dof_index);
                            state_next = ST_RDATA;
                        end
                        default: begin
                            load_res_null = 1'b1;
                            state_next    = ST_OUT;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                load_prod  = 1'b1;
                mem_rd     = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                load_c     = 1'b1;
                state_next = ST_WMUL;
            end
            ST_WMUL: begin
                load_wprod = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                mem_we     = 1'b1;
                mem_wdata  = {flag_new, acc_new};
                state_next = ST_IDLE;
            end
            ST_RDATA: begin
                load_res   = 1'b1;
                mem_we     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // exact sum of the enabled products, round half up, saturate to Q16.16
    always_comb begin
        sum66 = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            sum66 = sum66 + {{2{prod_reg[i][63]}}, prod_reg[i]};
        end
        sum66  = sum66 + 66'sd32768;
        c_wide = sum66[65:16];
        c_ovf  = !((&c_wide[49:31]) || !(|c_wide[49:31]));
        if (c_ovf) begin
            c_sat = c_wide[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            c_sat = c_wide[31:0];
        end
    end

    // weighted term rounded to Q32.16 and saturating add into the entry
    always_comb begin
        wround   = wprod_reg + 64'sd32768;
        term     = wround[63:16];
        acc_old  = rd_data_reg[ACC_W-1:0];
        acc_sum  = {acc_old[ACC_W-1], acc_old} + {term[ACC_W-1], term};
        acc_ovf  = acc_sum[ACC_W] != acc_sum[ACC_W-1];
        if (acc_ovf) begin
            acc_new = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_new = acc_sum[ACC_W-1:0];
        end
        flag_new = rd_data_reg[ACC_W] || csat_reg || acc_ovf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_job) begin
            job_reg <= job;
        end
        if (load_prod) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                if (job_reg.lane_en[i]) begin
                    prod_reg[i] <= job_reg.lhs[i] * job_reg.rhs[i];
                end else begin
                    prod_reg[i] <= '0;
                end
            end
        end
        if (load_c) begin
            c_reg    <= c_sat;
            csat_reg <= c_ovf;
        end
        if (load_wprod) begin
            wprod_reg <= job_reg.weight * c_reg;
        end
        if (load_res) begin
            res_total_reg <= rd_data_reg[ACC_W-1:0];
            res_sat_reg   <= rd_data_reg[ACC_W];
        end else if (load_res_null) begin
            res_total_reg <= '0;
            res_sat_reg   <= 1'b0;
        end
        if (load_out) begin
            m_data_reg.read_index <= job_reg.dof_index;
            m_data_reg.total      <= res_total_reg;
            m_data_reg.saturated  <= res_sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

endmodule

`default_nettype wire

/* design/fem_load_vector_scatter_add.sv */
// top level of the load vector scatter-add block
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    in_item_t (accumulate or read-and-clear)
//   m_        out        m_valid / m_ready    out_item_t (one per read)
//   cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// an accumulate runs through the back end as the pop, then all four lane products, the sum
// and round, the weight product and a read-modify-write of the memory
// a read takes and clears the entry, then waits for the output register to free up
// after reset a clearing pass writes zero to all NUM_DOFS entries, one per cycle,
// with s_ready low; config writes are taken during it
// the two-entry job queue keeps taking requests while a result waits on m_ready
`timescale 1ns / 1ps
`default_nettype none

module fem_load_vector_scatter_add #(
    parameter int NUM_DOFS = 4096
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire flvsa_pkg::in_item_t                s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output flvsa_pkg::out_item_t                    m_data,
    input  wire logic                               cfg_we,
    input  wire logic [flvsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [flvsa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import flvsa_pkg::*;

    cfg_t cfg_reg, cfg_next;
    job_t job;
    logic job_valid;
    logic job_ready;
    logic clear_busy;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_USE_VALUE: cfg_next.use_value_term    = cfg_wdata[0];
                CFG_USE_GRAD:  cfg_next.use_gradient_term = cfg_wdata[0];
                CFG_SPACE_DIM: cfg_next.space_dimension   = cfg_wdata[1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.use_value_term    <= 1'b1;
            cfg_reg.use_gradient_term <= 1'b0;
            cfg_reg.space_dimension   <= 2'd3;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    flvsa_front #(
        .NUM_DOFS (NUM_DOFS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg        (cfg_reg),
        .clear_busy (clear_busy),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job)
    );

    flvsa_back #(
        .NUM_DOFS (NUM_DOFS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .clear_busy (clear_busy),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for the load vector scatter-add block: predicts every read and checks it
`timescale 1ns / 1ps

module testbench;
    import flvsa_pkg::*;

    typedef logic signed [79:0] wide_t;

    localparam int    DOF_COUNT  = 4096;
    localparam int    QUIET_MAX  = 20000;
    localparam int    FLOOD_LEN  = 300;
    localparam int    SETTLE     = 40;
    localparam wide_t HALF_LSB   = 80'sd32768;
    localparam wide_t Q16_MAX    = 80'sd2147483647;
    localparam wide_t Q16_MIN    = -80'sd2147483648;
    localparam wide_t SUM_MAX    = 80'sd140737488355327;
    localparam wide_t SUM_MIN    = -80'sd140737488355328;
    localparam q16_t  ONE        = 32'sh0001_0000;
    localparam q16_t  QMAX       = 32'sh7fff_ffff;
    localparam q16_t  QMIN       = 32'sh8000_0000;

    // per phase {use_value, use_gradient, space_dimension[1:0]}, phase 0 rightmost
    localparam logic [6:0][3:0] PHASE_CFG = {
        4'b1111, 4'b0111, 4'b1100, 4'b0010, 4'b1110, 4'b0101, 4'b1011
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    fem_load_vector_scatter_add uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predicted block state and settings
    logic signed [ACC_W-1:0] dof_sums [DOF_COUNT];
    logic                    dof_sticky [DOF_COUNT];
    logic                    use_value  = 1'b1;
    logic                    use_grad   = 1'b0;
    logic [1:0]              grad_dims  = 2'd3;

    in_item_t  request_q [$];
    out_item_t totals_due [$];

    int          fail_count   = 0;
    int unsigned quiet_cycles = 0;
    bit          idle_on      = 1'b1;
    bit          flood_go     = 1'b0;
    bit          flood_done   = 1'b0;
    int          flood_left   = 0;
    int          src_gap      = 0;
    int          sink_gap     = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", msg);
    endtask

    // appends one request to the pending list
    task automatic add_request(input in_item_t r);
        request_q.insert(request_q.size(), r);
    endtask

    function automatic wide_t q_prod(input wide_t a, input wide_t b);
        return a * b;
    endfunction

    // updates the predicted store for one accepted request
    task automatic apply_request(input in_item_t req);
        wide_t     dot;
        wide_t     contrib;
        wide_t     load;
        wide_t     upd;
        logic      hit_sat;
        out_item_t res;
        if (req.command == CMD_READ) begin
            res.read_index = req.dof_index;
            res.total      = dof_sums[req.dof_index];
            res.saturated  = dof_sticky[req.dof_index];
            dof_sums[req.dof_index]   = '0;
            dof_sticky[req.dof_index] = 1'b0;
            totals_due.insert(totals_due.size(), res);
        end else begin
            dot     = '0;
            hit_sat = 1'b0;
            if (use_value) dot += q_prod(req.shape_value, req.value_coef);
            if (use_grad && grad_dims >= 2'd1) dot += q_prod(req.shape_grad_x, req.coef_grad_x);
            if (use_grad && grad_dims >= 2'd2) dot += q_prod(req.shape_grad_y, req.coef_grad_y);
            if (use_grad && grad_dims >= 2'd3) dot += q_prod(req.shape_grad_z, req.coef_grad_z);
            contrib = (dot + HALF_LSB) >>> 16;
            if (contrib > Q16_MAX) begin
                contrib = Q16_MAX;
                hit_sat = 1'b1;
            end else if (contrib < Q16_MIN) begin
                contrib = Q16_MIN;
                hit_sat = 1'b1;
            end
            load = (q_prod(req.weight, contrib) + HALF_LSB) >>> 16;
            upd  = dof_sums[req.dof_index];
            upd  = upd + load;
            if (upd > SUM_MAX) begin
                upd     = SUM_MAX;
                hit_sat = 1'b1;
            end else if (upd < SUM_MIN) begin
                upd     = SUM_MIN;
                hit_sat = 1'b1;
            end
            dof_sums[req.dof_index] = upd[ACC_W-1:0];
            if (hit_sat) dof_sticky[req.dof_index] = 1'b1;
        end
    endtask

    function automatic q16_t rand_q16();
        q16_t v;
        case ($urandom_range(0, 19))
            0:       v = QMIN;
            1:       v = QMAX;
            2, 3, 4: v = $urandom();
            default: v = $urandom_range(0, 32'h000a_0000) - 32'h0005_0000;
        endcase
        return v;
    endfunction

    function automatic in_item_t point_req(input logic [IDX_W-1:0] dof, input q16_t w,
                                           input q16_t sv, input q16_t vc,
                                           input q16_t gx, input q16_t gy, input q16_t gz,
                                           input q16_t cx, input q16_t cy, input q16_t cz);
        in_item_t r;
        r.command      = CMD_ACCUMULATE;
        r.dof_index    = dof;
        r.weight       = w;
        r.shape_value  = sv;
        r.value_coef   = vc;
        r.shape_grad_x = gx;
        r.shape_grad_y = gy;
        r.shape_grad_z = gz;
        r.coef_grad_x  = cx;
        r.coef_grad_y  = cy;
        r.coef_grad_z  = cz;
        return r;
    endfunction

    function automatic in_item_t rand_point(input logic [IDX_W-1:0] dof);
        return point_req(dof, rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                         rand_q16(), rand_q16(), rand_q16(), rand_q16());
    endfunction

    // read with random payload in the unused fields
    function automatic in_item_t read_req(input logic [IDX_W-1:0] dof);
        in_item_t r;
        r = rand_point(dof);
        r.command = CMD_READ;
        return r;
    endfunction

    task automatic set_config(input logic v, input logic g, input logic [1:0] d);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_USE_VALUE;
        cfg_wdata <= {1'($urandom_range(0, 1)), v};
        @(posedge aclk);
        cfg_index <= CFG_USE_GRAD;
        cfg_wdata <= {1'($urandom_range(0, 1)), g};
        @(posedge aclk);
        cfg_index <= CFG_SPACE_DIM;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        use_value = v;
        use_grad  = g;
        grad_dims = d;
    endtask

    // accumulates may still be in the pipe after the last read returns
    task automatic wait_idle();
        do @(negedge aclk);
        while (request_q.size() != 0 || s_valid || totals_due.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // cells of neighboring dofs: a few points each, then most dofs read back; lone random requests mixed in
    task automatic queue_cells(input int target);
        int made;
        int n_dofs;
        int n_pts;
        logic [IDX_W-1:0] base;
        made = 0;
        while (made < target) begin
            if ($urandom_range(0, 9) == 0) begin
                base = IDX_W'($urandom_range(0, DOF_COUNT - 1));
                if ($urandom_range(0, 1)) add_request(read_req(base));
                else add_request(rand_point(base));
                made++;
            end else begin
                if ($urandom_range(0, 7) == 0) base = IDX_W'($urandom_range(0, DOF_COUNT - 1));
                else base = IDX_W'($urandom_range(0, 47));
                n_dofs = $urandom_range(2, 4);
                n_pts  = $urandom_range(1, 3);
                for (int p = 0; p < n_pts; p++) begin
                    for (int k = 0; k < n_dofs; k++) begin
                        add_request(rand_point(base + IDX_W'(k)));
                        made++;
                    end
                end
                for (int k = 0; k < n_dofs; k++) begin
                    if ($urandom_range(0, 4) != 0) begin
                        add_request(read_req(base + IDX_W'(k)));
                        made++;
                    end
                end
            end
        end
    endtask

    // request side: predict on accept, then offer the next one unless idling
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_request(s_data);
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    s_data  <= request_q.pop_front();
                    s_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 4);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (flood_left > 0) begin
            flood_left--;
            m_ready <= 1'b0;
        end else if (flood_go && !flood_done) begin
            flood_done = 1'b1;
            flood_left = FLOOD_LEN;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 6) == 0) sink_gap = $urandom_range(1, 4);
        end
    end

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (totals_due.size() == 0) begin
                flag_error($sformatf("unexpected result idx=%0d total=%0d sat=%0b",
                                     m_data.read_index, m_data.total, m_data.saturated));
            end else begin
                want = totals_due.pop_front();
                if (m_data.read_index !== want.read_index)
                    flag_error($sformatf("read_index exp=%0d got=%0d",
                                         want.read_index, m_data.read_index));
                if (m_data.total !== want.total)
                    flag_error($sformatf("total idx=%0d exp=%0d got=%0d",
                                         want.read_index, want.total, m_data.total));
                if (m_data.saturated !== want.saturated)
                    flag_error($sformatf("saturated idx=%0d exp=%0b got=%0b",
                                         want.read_index, want.saturated, m_data.saturated));
            end
        end
    end

    // covers the clearing pass after reset and the long hold-off
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("[fem_load_vector_scatter_add] ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [3:0] pc;
        for (int i = 0; i < DOF_COUNT; i++) begin
            dof_sums[i]   = '0;
            dof_sticky[i] = 1'b0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        set_config(1'b1, 1'b1, 2'd3);
        // unit inputs, then a second read of the cleared entry
        add_request(point_req(IDX_W'(0), ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        add_request(read_req(IDX_W'(0)));
        add_request(read_req(IDX_W'(0)));
        // all-negative and all-positive extremes overflow the contribution
        add_request(point_req(IDX_W'(4095), QMIN, QMIN, QMIN, QMIN, QMIN, QMIN,
                              QMIN, QMIN, QMIN));
        add_request(read_req(IDX_W'(4095)));
        add_request(point_req(IDX_W'(1), QMAX, QMAX, QMAX, QMAX, QMAX, QMAX,
                              QMAX, QMAX, QMAX));
        add_request(read_req(IDX_W'(1)));
        // accumulator overflow toward each bound, contribution itself in range
        repeat (3) add_request(point_req(IDX_W'(2), QMIN, QMIN, ONE, 0, 0, 0, 0, 0, 0));
        add_request(read_req(IDX_W'(2)));
        repeat (3) add_request(point_req(IDX_W'(3), QMAX, QMIN, ONE, 0, 0, 0, 0, 0, 0));
        add_request(read_req(IDX_W'(3)));
        // ties in both rounding steps
        add_request(point_req(IDX_W'(5), ONE, 32'sd1, 32'sh0000_8000, 0, 0, 0, 0, 0, 0));
        add_request(point_req(IDX_W'(5), ONE, -32'sd1, 32'sh0000_8000, 0, 0, 0, 0, 0, 0));
        add_request(point_req(IDX_W'(5), 32'sh0000_8000, 32'sd1, ONE, 0, 0, 0, 0, 0, 0));
        add_request(point_req(IDX_W'(5), 32'shffff_8000, 32'sd1, ONE, 0, 0, 0, 0, 0, 0));
        add_request(read_req(IDX_W'(5)));
        // distinct gradient lanes
        add_request(point_req(IDX_W'(6), ONE, 0, 0, ONE, ONE, ONE,
                              2 * ONE, 3 * ONE, 5 * ONE));
        add_request(read_req(IDX_W'(6)));
        wait_idle();

        for (int ph = 0; ph < 7; ph++) begin
            pc = PHASE_CFG[ph];
            set_config(pc[3], pc[2], pc[1:0]);
            idle_on = (ph != 6);
            if (ph == 2) flood_go = 1'b1;
            queue_cells(62);
            wait_idle();
        end

        if (fail_count == 0 && totals_due.size() == 0) begin
            $display("[fem_load_vector_scatter_add] OK");
        end else begin
            $display("[fem_load_vector_scatter_add] ERROR");
        end
        $finish;
    end

endmodule
